@@ src/homogeneous_vertex_transform_core_macros.svh @@
// Assertion macros used by the checker of the vertex transform core.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_MACROS_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hvt_pkg.sv @@
// Shared constants, types and reset values of the vertex transform core.
package hvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int NUM_PAIRS = 8;
    localparam int PAIR_W    = 64;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_ENTRIES = 2 * NUM_PAIRS;
    localparam int MAT_DIM   = 4;
    localparam int VEC_DIM   = 3;

    localparam int PROD_W = 2 * COORD_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int ACC_W  = TERM_W + 2;
    localparam int QUO_W  = COORD_W;
    localparam int REM_W  = ACC_W + QUO_W;

    localparam logic [COORD_W-1:0] ENTRY_ONE = COORD_W'(1) << FRAC_BITS;
    localparam logic [COORD_W-1:0] ENTRY_ZERO = '0;
    localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] pairs_t;
    typedef logic [NUM_ENTRIES-1:0][COORD_W-1:0] matrix_t;
    typedef logic [MAT_DIM-1:0][ACC_W-1:0] acc_vec_t;

    // Identity matrix, one diagonal entry in each row.
    localparam pairs_t PAIRS_RESET = {
        {ENTRY_ONE,  ENTRY_ZERO},   // m32, m33
        {ENTRY_ZERO, ENTRY_ZERO},   // m30, m31
        {ENTRY_ZERO, ENTRY_ONE},    // m22, m23
        {ENTRY_ZERO, ENTRY_ZERO},   // m20, m21
        {ENTRY_ZERO, ENTRY_ZERO},   // m12, m13
        {ENTRY_ONE,  ENTRY_ZERO},   // m10, m11
        {ENTRY_ZERO, ENTRY_ZERO},   // m02, m03
        {ENTRY_ZERO, ENTRY_ONE}     // m00, m01
    };

    typedef struct packed {
        logic [COORD_W-1:0] value;
        logic               sat;
        logic               zero;
    } lane_res_t;

    typedef struct packed {
        logic [COORD_W-1:0] x_out;
        logic [COORD_W-1:0] y_out;
        logic [COORD_W-1:0] z_out;
        logic               w_zero;
        logic               saturated;
    } out_beat_t;

endpackage

@@ src/hvt_vertex_if.sv @@
// Vertex input channel: valid, ready and the three coordinates.
interface hvt_vertex_if;
    import hvt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

@@ src/hvt_result_if.sv @@
// Result output channel: valid, ready, the divided point and its flags.
interface hvt_result_if;
    import hvt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic                      w_zero;
    logic                      saturated;

    modport source (output valid, output x_out, output y_out, output z_out,
                    output w_zero, output saturated, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out,
                    input w_zero, input saturated, output ready);
endinterface

@@ src/hvt_mac.sv @@
// Matrix-vector product: three stages of multiply, pair sums and row sums.
module hvt_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [hvt_pkg::COORD_W-1:0] x,
    input  logic signed [hvt_pkg::COORD_W-1:0] y,
    input  logic signed [hvt_pkg::COORD_W-1:0] z,
    input  hvt_pkg::pairs_t                   matrix,
    output logic                              out_valid,
    output hvt_pkg::acc_vec_t                 acc
);
    import hvt_pkg::*;

    matrix_t m;
    logic signed [COORD_W-1:0] v [VEC_DIM];

    logic signed [PROD_W-1:0]  prod_reg [MAT_DIM][VEC_DIM];
    logic signed [COORD_W-1:0] bias_reg [MAT_DIM];
    logic                      v1_reg;

    logic signed [TERM_W:0]    pa_next [MAT_DIM];
    logic signed [TERM_W:0]    pb_next [MAT_DIM];
    logic signed [TERM_W:0]    pa_reg [MAT_DIM];
    logic signed [TERM_W:0]    pb_reg [MAT_DIM];
    logic                      v2_reg;

    acc_vec_t                  acc_reg;
    logic                      v3_reg;

    assign m = matrix_t'(matrix);

    always_comb
    begin
        v[0] = x;
        v[1] = y;
        v[2] = z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < MAT_DIM; r++)
            begin
                for (int c = 0; c < VEC_DIM; c++)
                begin
                    prod_reg[r][c] <= $signed(m[r*MAT_DIM + c]) * v[c];
                end
                bias_reg[r] <= $signed(m[r*MAT_DIM + VEC_DIM]);
            end
        end
    end

    // Floor shift of each product, then pair up the four row terms.
    always_comb
    begin
        logic signed [TERM_W-1:0] t [VEC_DIM];
        for (int r = 0; r < MAT_DIM; r++)
        begin
            for (int c = 0; c < VEC_DIM; c++)
            begin
                t[c] = TERM_W'(prod_reg[r][c] >>> FRAC_BITS);
            end
            pa_next[r] = (TERM_W+1)'(t[0]) + (TERM_W+1)'(t[1]);
            pb_next[r] = (TERM_W+1)'(t[2]) + (TERM_W+1)'(bias_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < MAT_DIM; r++)
            begin
                pa_reg[r]  <= pa_next[r];
                pb_reg[r]  <= pb_next[r];
                acc_reg[r] <= ACC_W'(pa_reg[r]) + ACC_W'(pb_reg[r]);
            end
        end
    end

    assign out_valid = v3_reg;
    assign acc       = acc_reg;
endmodule

@@ src/hvt_div_lane.sv @@
// One coordinate lane: sign split, overflow check, bit-per-stage quotient, clamp.
module hvt_div_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [hvt_pkg::ACC_W-1:0] num,
    input  logic signed [hvt_pkg::ACC_W-1:0] den,
    output logic                             out_valid,
    output hvt_pkg::lane_res_t               res
);
    import hvt_pkg::*;

    // Sign and magnitude stage
    logic             va_reg;
    logic             nega_reg;
    logic             zeroa_reg;
    logic [ACC_W-1:0] magn_reg;
    logic [ACC_W-1:0] magd_reg;

    // Quotient chain; index 0 is the overflow-check stage
    logic             vq_reg   [QUO_W+1];
    logic             negq_reg [QUO_W+1];
    logic             zeroq_reg[QUO_W+1];
    logic             big_reg  [QUO_W+1];
    logic [ACC_W-1:0] den_reg  [QUO_W+1];
    logic [REM_W-1:0] rem_reg  [QUO_W+1];
    logic [QUO_W-1:0] quo_reg  [QUO_W+1];

    logic             vo_reg;
    lane_res_t        res_reg;
    lane_res_t        res_next;
    logic [REM_W-1:0] rem0_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nega_reg  <= num[ACC_W-1] ^ den[ACC_W-1];
            zeroa_reg <= (den == '0);
            magn_reg  <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
            magd_reg  <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
        end
    end

    assign rem0_next = REM_W'({magn_reg, {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vq_reg[0] <= va_reg;
        end
    end

    // Quotient of 2^32 or more saturates whatever the sign.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            negq_reg[0]  <= nega_reg;
            zeroq_reg[0] <= zeroa_reg;
            big_reg[0]   <= rem0_next >= (REM_W'(magd_reg) << QUO_W);
            den_reg[0]   <= magd_reg;
            rem_reg[0]   <= rem0_next;
            quo_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_step
        localparam int SHIFT = QUO_W - 1 - i;
        logic [REM_W-1:0] trial;
        logic             fits;

        assign trial = REM_W'(den_reg[i]) << SHIFT;
        assign fits  = rem_reg[i] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vq_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vq_reg[i+1] <= vq_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                negq_reg[i+1]  <= negq_reg[i];
                zeroq_reg[i+1] <= zeroq_reg[i];
                big_reg[i+1]   <= big_reg[i];
                den_reg[i+1]   <= den_reg[i];
                rem_reg[i+1]   <= fits ? rem_reg[i] - trial : rem_reg[i];
                quo_reg[i+1]   <= {quo_reg[i][QUO_W-2:0], fits};
            end
        end
    end

    // Clamp and apply the sign; a zero w forces a clean zero.
    always_comb
    begin
        logic [QUO_W-1:0] q;
        q = quo_reg[QUO_W];
        res_next.zero = zeroq_reg[QUO_W];
        res_next.sat  = 1'b0;
        if (zeroq_reg[QUO_W])
        begin
            res_next.value = '0;
        end
        else if (negq_reg[QUO_W])
        begin
            if (big_reg[QUO_W] || q > SAT_NEG)
            begin
                res_next.value = SAT_NEG;
                res_next.sat   = 1'b1;
            end
            else
            begin
                res_next.value = -q;
            end
        end
        else
        begin
            if (big_reg[QUO_W] || q > SAT_POS)
            begin
                res_next.value = SAT_POS;
                res_next.sat   = 1'b1;
            end
            else
            begin
                res_next.value = q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= vq_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = vo_reg;
    assign res       = res_reg;
endmodule

@@ src/hvt_skid.sv @@
// Output register with a skid entry so the pipeline keeps moving under a stall until the skid entry fills.
module hvt_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               p_valid,
    output logic               p_ready,
    input  hvt_pkg::out_beat_t p_data,
    hvt_result_if.source       result
);
    import hvt_pkg::*;

    logic      o_valid_reg;
    logic      s_valid_reg;
    out_beat_t o_data_reg;
    out_beat_t s_data_reg;
    logic      pop;
    logic      push;

    assign p_ready = !s_valid_reg;
    assign pop     = o_valid_reg && result.ready;
    assign push    = p_valid && p_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (s_valid_reg)
        begin
            if (pop)
            begin
                s_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (o_valid_reg && !pop)
            begin
                s_valid_reg <= 1'b1;
            end
            o_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid_reg)
        begin
            if (pop)
            begin
                o_data_reg <= s_data_reg;
            end
        end
        else if (push)
        begin
            if (o_valid_reg && !pop)
            begin
                s_data_reg <= p_data;
            end
            else
            begin
                o_data_reg <= p_data;
            end
        end
    end

    assign result.valid     = o_valid_reg;
    assign result.x_out     = o_data_reg.x_out;
    assign result.y_out     = o_data_reg.y_out;
    assign result.z_out     = o_data_reg.z_out;
    assign result.w_zero    = o_data_reg.w_zero;
    assign result.saturated = o_data_reg.saturated;
endmodule

@@ src/homogeneous_vertex_transform_core.sv @@
// Top level of the homogeneous vertex transform core.
// Accepts one vertex per cycle while ready is high and returns one
// transformed, w-divided point per vertex, in order. An accepted vertex
// passes through the matrix multiply and row sums, sign split and overflow
// check, the quotient (one bit per stage in each of three parallel lanes),
// the clamp and one output register before its result reaches the output.
// The vertex port drops ready only while a second result sits in the skid
// entry behind a stalled output. Matrix writes take effect at once and are
// meant for idle periods; indexes past the last pair are ignored.
module homogeneous_vertex_transform_core (
    input  logic                              clk,
    input  logic                              rst_n,
    hvt_vertex_if.sink                        vertex,
    hvt_result_if.source                      result,
    input  logic                              cfg_wr_en,
    input  logic [hvt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hvt_pkg::PAIR_W-1:0]        cfg_data
);
    import hvt_pkg::*;

    pairs_t             pairs_reg;
    logic               en;
    logic               mac_valid;
    acc_vec_t           acc;
    logic [VEC_DIM-1:0] lane_valid;
    lane_res_t          lane_res [VEC_DIM];
    out_beat_t          beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg <= PAIRS_RESET;
        end
        else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_PAIRS)))
        begin
            pairs_reg[cfg_index[$clog2(NUM_PAIRS)-1:0]] <= cfg_data;
        end
    end

    assign vertex.ready = en;

    hvt_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vertex.valid),
        .x         (vertex.x_in),
        .y         (vertex.y_in),
        .z         (vertex.z_in),
        .matrix    (pairs_reg),
        .out_valid (mac_valid),
        .acc       (acc)
    );

    for (genvar i = 0; i < VEC_DIM; i++)
    begin : g_lane
        hvt_div_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (mac_valid),
            .num       ($signed(acc[i])),
            .den       ($signed(acc[MAT_DIM-1])),
            .out_valid (lane_valid[i]),
            .res       (lane_res[i])
        );
    end

    always_comb
    begin
        beat.x_out     = lane_res[0].value;
        beat.y_out     = lane_res[1].value;
        beat.z_out     = lane_res[2].value;
        beat.w_zero    = lane_res[0].zero;
        beat.saturated = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
    end

    // All lanes move in lockstep; the beat is valid when every lane's valid is set.
    hvt_skid u_skid (
        .clk     (clk),
        .rst_n   (rst_n),
        .p_valid (&lane_valid),
        .p_ready (en),
        .p_data  (beat),
        .result  (result)
    );
endmodule

@@ src/hvt_checker.sv @@
// Port-level checker of the vertex transform core and its bind.
`include "homogeneous_vertex_transform_core_macros.svh"

module hvt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [hvt_pkg::COORD_W-1:0] x_out,
    input logic [hvt_pkg::COORD_W-1:0] y_out,
    input logic [hvt_pkg::COORD_W-1:0] z_out,
    input logic                        w_zero,
    input logic                        saturated
);
    import hvt_pkg::*;

    // An empty output stage means the skid entry is empty too.
    `HVT_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

    `HVT_ASSERT_NOW(a_wzero_clean, out_valid && w_zero, (x_out == '0) && (y_out == '0) && (z_out == '0) && !saturated, "zero w result not clean")

    `HVT_ASSERT_NOW(a_sat_value, out_valid && saturated, !w_zero && ((x_out == SAT_POS) || (x_out == SAT_NEG) || (y_out == SAT_POS) || (y_out == SAT_NEG) || (z_out == SAT_POS) || (z_out == SAT_NEG)), "saturated flag without clamped value")

    `HVT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(x_out) && $stable(y_out) && $stable(z_out), "stalled result changed")
endmodule

bind homogeneous_vertex_transform_core hvt_checker u_hvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (vertex.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .x_out     (result.x_out),
    .y_out     (result.y_out),
    .z_out     (result.z_out),
    .w_zero    (result.w_zero),
    .saturated (result.saturated)
);
